// ===== rtl/gtu_pkg.sv =====
// ----------------------------------------------------------------------------
// gtu_pkg
// Shared widths, byte ranges and item codes of the GB2312 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package gtu_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 14;
    localparam int CODE_W = 16;
    localparam int CNT_W  = 12;
    localparam int OFF_W  = 7;

    // item kinds
    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [BYTE_W-1:0] ASCII_END = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_MIN  = 8'hA0;
    localparam logic [BYTE_W-1:0] LEAD_END  = 8'hF8;
    localparam logic [BYTE_W-1:0] TRAIL_MIN = 8'hA1;
    localparam logic [BYTE_W-1:0] TRAIL_END = 8'hFF;
    localparam logic [OFF_W-1:0]  ZONE_SIZE = 7'd94;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 12'hFFF;

    // result in flight between the lookup issue and the output register
    typedef struct packed {
        logic              use_mem;
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  number;
        logic              last;
    } t_result;

endpackage

// ===== rtl/gtu_if.sv =====
// ----------------------------------------------------------------------------
// gtu_in_if / gtu_out_if
// Valid/ready channels carrying input items and decoded code units.
// ----------------------------------------------------------------------------
interface gtu_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [gtu_pkg::BYTE_W-1:0]  byte_value;
    logic                        end_of_text;
    logic [gtu_pkg::IDX_W-1:0]   entry_index;
    logic [gtu_pkg::CODE_W-1:0]  entry_code;

    modport source (
        output valid, kind, byte_value, end_of_text, entry_index, entry_code,
        input  ready
    );
    modport sink (
        input  valid, kind, byte_value, end_of_text, entry_index, entry_code,
        output ready
    );
endinterface

interface gtu_out_if;
    logic                        valid;
    logic                        ready;
    logic [gtu_pkg::CODE_W-1:0]  code_unit;
    logic [gtu_pkg::CNT_W-1:0]   char_number;
    logic                        last_of_text;

    modport source (
        output valid, code_unit, char_number, last_of_text,
        input  ready
    );
    modport sink (
        input  valid, code_unit, char_number, last_of_text,
        output ready
    );
endinterface

// ===== rtl/gtu_map_mem.sv =====
// ----------------------------------------------------------------------------
// gtu_map_mem
// Mapping table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gtu_map_mem #(
    parameter int DEPTH = 8272,
    parameter int AW    = 14
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [gtu_pkg::CODE_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [gtu_pkg::CODE_W-1:0] o_rd_data
);
    import gtu_pkg::*;

    logic [CODE_W-1:0] r_mem [DEPTH];
    logic [CODE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/gb2312_to_ucs2_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// gb2312_to_ucs2_decoder_unit
// Decodes a GB2312 byte stream into UCS-2 code units through a loaded table.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per handshake: a text byte (kind 0) or a write of
//   one mapping table entry (kind 1). o_out carries the decoded code units
//   with their position in the text and a last-of-text flag.
//   A byte below 0x80 gives a result on its own; a lead byte gives its result
//   with the following byte. Table writes give no result.
//   Throughput: one item per cycle while o_out is not back-pressured;
//   a write and the next lookup of the same entry may follow back to back.
//   Each result passes through the lookup stage (table read) and then the
//   output register before it appears on o_out.
//   Reset clears the decode phase, the held lead and the character counter;
//   the table itself is not cleared and must be loaded before use.
//   When the receiver stalls, the output register and the lookup stage each
//   keep one item, so one more result-bearing item is accepted before
//   i_in.ready drops; table writes and lead bytes are still taken until then.
// ----------------------------------------------------------------------------
module gb2312_to_ucs2_decoder_unit #(
    parameter int TABLE_ENTRIES = 8272
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gtu_in_if.sink    i_in,
    gtu_out_if.source o_out
);
    import gtu_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LEAD    = 2'd1,
        PH_SWALLOW = 2'd2
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_lead, n_lead;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              r_s1_valid;
    t_result           r_s1, n_s1;
    logic              n_emit;

    logic              r_o_valid;
    logic [CODE_W-1:0] r_o_code;
    logic [CNT_W-1:0]  r_o_number;
    logic              r_o_last;

    logic              out_free, s1_move, accept, is_text, is_write;
    logic [BYTE_W-1:0] b;
    logic [OFF_W-1:0]  lead_off, trail_off;
    logic [IDX_W-1:0]  lookup_idx;
    logic              trail_ok, idx_ok, rd_en, wr_en;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CODE_W-1:0] rd_data;

    assign out_free    = !r_o_valid || o_out.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign i_in.ready  = !r_s1_valid || out_free;
    assign accept      = i_in.valid && i_in.ready;
    assign is_text     = accept && (i_in.kind == KIND_TEXT);
    assign is_write    = accept && (i_in.kind == KIND_WRITE);
    assign b           = i_in.byte_value;

    // table index from the held lead and this trail
    assign lead_off    = OFF_W'(r_lead - LEAD_MIN);
    assign trail_off   = OFF_W'(b - TRAIL_MIN);
    assign lookup_idx  = IDX_W'(trail_off) + IDX_W'(lead_off) * IDX_W'(ZONE_SIZE);
    assign trail_ok    = (b >= TRAIL_MIN) && (b < TRAIL_END);
    assign idx_ok      = 32'(lookup_idx) < TABLE_ENTRIES;
    assign cnt_inc     = (r_cnt != CNT_MAX) ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        n_phase       = r_phase;
        n_lead        = r_lead;
        n_cnt         = r_cnt;
        n_emit        = 1'b0;
        n_s1.use_mem  = 1'b0;
        n_s1.code     = '0;
        n_s1.number   = cnt_inc;
        n_s1.last     = i_in.end_of_text;
        rd_en         = 1'b0;
        if (is_text) begin
            unique case (r_phase)
                PH_LEAD: begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                    if (trail_ok && idx_ok) begin
                        n_s1.use_mem = 1'b1;
                        rd_en        = 1'b1;
                    end
                end
                PH_SWALLOW: begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (b < ASCII_END) begin
                        n_emit    = 1'b1;
                        n_s1.code = CODE_W'(b);
                    end else if (i_in.end_of_text) begin
                        n_emit = 1'b1;
                    end else if (b >= LEAD_MIN && b < LEAD_END) begin
                        n_lead  = b;
                        n_phase = PH_LEAD;
                    end else begin
                        n_phase = PH_SWALLOW;
                    end
                end
            endcase
            if (n_emit) begin
                n_cnt = i_in.end_of_text ? '0 : cnt_inc;
                if (i_in.end_of_text) begin
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    assign wr_en = is_write && (32'(i_in.entry_index) < TABLE_ENTRIES);

    gtu_map_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_map_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in.entry_index[AW-1:0]),
        .i_wr_data (i_in.entry_code),
        .i_rd_en   (rd_en),
        .i_rd_addr (lookup_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_lead     <= '0;
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_lead  <= n_lead;
            r_cnt   <= n_cnt;
            if (accept) begin
                r_s1_valid <= n_emit;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            // payload registers
            if (accept && n_emit) begin
                r_s1 <= n_s1;
            end
            if (s1_move) begin
                r_o_code   <= r_s1.use_mem ? rd_data : r_s1.code;
                r_o_number <= r_s1.number;
                r_o_last   <= r_s1.last;
            end
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.code_unit    = r_o_code;
    assign o_out.char_number  = r_o_number;
    assign o_out.last_of_text = r_o_last;

endmodule

// ===== tb/sv/tb_gb2312_to_ucs2_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_gb2312_to_ucs2_decoder_unit
// Self-checking bench for the GB2312 to UCS-2 decoder. A behavioral decoder
// with its own table copy predicts every code unit as items are accepted, and
// a monitor compares each unit on the output channel, with random gaps and
// stalls on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_gb2312_to_ucs2_decoder_unit;
    import gtu_pkg::*;

    localparam int TABLE_ENTRIES  = 8272;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {DEC_IDLE, DEC_LEAD, DEC_SKIP} t_dec_phase;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] byte_v;
        logic              eot;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
    } t_gb_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  number;
        logic              last;
    } t_ucs_unit;

    logic clk;
    logic rst_n;

    gtu_in_if  byte_ch ();
    gtu_out_if unit_ch ();

    gb2312_to_ucs2_decoder_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (byte_ch),
        .o_out  (unit_ch)
    );

    // decoder mirror
    logic [CODE_W-1:0] table_mirror [TABLE_ENTRIES];
    bit                entry_loaded [TABLE_ENTRIES];
    logic [BYTE_W-1:0] held_lead_m;
    t_dec_phase        phase_m;
    logic [CNT_W-1:0]  char_count_m;
    t_ucs_unit         pending_units [$];

    int  mismatches;
    int  items_sent;
    bit  src_jitter;
    bit  sink_jitter;
    int  sink_hold_req;
    int  idle_cycles;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    // table address read for a lead/trail pair, -1 when no read happens
    function automatic int table_slot(logic [BYTE_W-1:0] lead, logic [BYTE_W-1:0] trail);
        int slot;
        if (trail < TRAIL_MIN || trail >= TRAIL_END) return -1;
        slot = int'(trail - TRAIL_MIN) + int'(lead - LEAD_MIN) * int'(ZONE_SIZE);
        if (slot >= TABLE_ENTRIES) return -1;
        return slot;
    endfunction

    function automatic void push_unit(logic [CODE_W-1:0] code, logic last);
        t_ucs_unit u;
        if (char_count_m < CNT_MAX) char_count_m++;
        u.code   = code;
        u.number = char_count_m;
        u.last   = last;
        pending_units.push_back(u);
        if (last) begin
            char_count_m = '0;
            phase_m      = DEC_IDLE;
        end
    endfunction

    function automatic void decode_byte(logic [BYTE_W-1:0] b, logic eot);
        int slot;
        if (phase_m == DEC_LEAD) begin
            phase_m = DEC_IDLE;
            slot    = table_slot(held_lead_m, b);
            push_unit((slot < 0) ? '0 : table_mirror[slot], eot);
        end else if (phase_m == DEC_SKIP) begin
            phase_m = DEC_IDLE;
            push_unit('0, eot);
        end else begin
            phase_m = DEC_IDLE;
            if (b < ASCII_END) begin
                push_unit({8'h00, b}, eot);
            end else if (eot) begin
                push_unit('0, 1'b1);
            end else if (b >= LEAD_MIN && b < LEAD_END) begin
                held_lead_m = b;
                phase_m     = DEC_LEAD;
            end else begin
                phase_m = DEC_SKIP;
            end
        end
    endfunction

    function automatic void absorb_item(t_gb_item it);
        if (it.kind == KIND_WRITE) begin
            if (it.idx < TABLE_ENTRIES) begin
                table_mirror[it.idx] = it.code;
                entry_loaded[it.idx] = 1'b1;
                items_sent++;
            end
        end else begin
            decode_byte(it.byte_v, it.eot);
            items_sent++;
        end
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    function automatic t_gb_item text_item(logic [BYTE_W-1:0] b, logic eot);
        t_gb_item it;
        it.kind   = KIND_TEXT;
        it.byte_v = b;
        it.eot    = eot;
        it.idx    = IDX_W'($urandom_range(0, 16383));
        it.code   = CODE_W'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic t_gb_item write_item(int idx, logic [CODE_W-1:0] code);
        t_gb_item it;
        it.kind   = KIND_WRITE;
        it.byte_v = BYTE_W'($urandom_range(0, 255));
        it.eot    = 1'($urandom_range(0, 1));
        it.idx    = IDX_W'(idx);
        it.code   = code;
        return it;
    endfunction

    // valid stays high between back-to-back items; it only drops for a gap
    task automatic send_item(input t_gb_item it);
        if (src_jitter && $urandom_range(0, 5) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.kind        <= it.kind;
        byte_ch.byte_value  <= it.byte_v;
        byte_ch.end_of_text <= it.eot;
        byte_ch.entry_index <= it.idx;
        byte_ch.entry_code  <= it.code;
        @(posedge clk);
        while (byte_ch.ready !== 1'b1) @(posedge clk);
        absorb_item(it);
    endtask

    task automatic write_entry(input int idx, input logic [CODE_W-1:0] code);
        send_item(write_item(idx, code));
    endtask

    // a trail that reads a never-loaded entry gets that entry loaded first
    task automatic send_text(input logic [BYTE_W-1:0] b, input logic eot);
        int slot;
        if (phase_m == DEC_LEAD) begin
            slot = table_slot(held_lead_m, b);
            if (slot >= 0 && !entry_loaded[slot]) begin
                write_entry(slot, CODE_W'($urandom_range(0, 65535)));
            end
        end
        send_item(text_item(b, eot));
    endtask

    task automatic random_write();
        int idx;
        case ($urandom_range(0, 7))
            0:       idx = $urandom_range(TABLE_ENTRIES, 16383);
            1, 2, 3: idx = $urandom_range(0, 299);
            default: idx = $urandom_range(0, TABLE_ENTRIES - 1);
        endcase
        write_entry(idx, CODE_W'($urandom_range(0, 65535)));
    endtask

    // pause the sender until every predicted unit has come out
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_units.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver, checker, watchdog
    // ------------------------------------------------------------------
    initial begin : sink_proc
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        unit_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                unit_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                unit_ch.ready <= 1'b0;
            end else if (sink_jitter && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                unit_ch.ready <= 1'b0;
            end else begin
                unit_ch.ready <= 1'b1;
            end
        end
    end

    function automatic void report_mismatch(string what, t_ucs_unit want, t_ucs_unit got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch (%s): expected code=%h number=%0d last=%b,",
                     what, want.code, want.number, want.last);
            $display("    got code=%h number=%0d last=%b",
                     got.code, got.number, got.last);
        end
    endfunction

    always @(posedge clk) begin : check_units
        t_ucs_unit got;
        t_ucs_unit want;
        if (rst_n && unit_ch.valid && unit_ch.ready) begin
            got.code   = unit_ch.code_unit;
            got.number = unit_ch.char_number;
            got.last   = unit_ch.last_of_text;
            if (pending_units.size() == 0) begin
                report_mismatch("unexpected unit", '0, got);
            end else begin
                want = pending_units.pop_front();
                if (got.code !== want.code) report_mismatch("code_unit", want, got);
                else if (got.number !== want.number) report_mismatch("char_number", want, got);
                else if (got.last !== want.last) report_mismatch("last_of_text", want, got);
            end
        end
    end

    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("** gb2312_to_ucs2_decoder_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        write_entry(0, 16'hFFFF);
        write_entry(TABLE_ENTRIES - 1, 16'h8000);
        write_entry(16383, 16'h5555);           // past the table, ignored
        write_entry(TABLE_ENTRIES, 16'hAAAA);   // first index past the table
        send_text(8'h00, 1'b0);
        send_text(8'h7F, 1'b0);
        send_text(LEAD_MIN, 1'b0);              // first table entry
        send_text(TRAIL_MIN, 1'b0);
        send_text(BYTE_W'(LEAD_END - 1), 1'b0); // last table entry
        send_text(BYTE_W'(TRAIL_END - 1), 1'b0);
        send_text(LEAD_MIN, 1'b0);              // trail just below range
        send_text(BYTE_W'(TRAIL_MIN - 1), 1'b0);
        send_text(BYTE_W'(LEAD_END - 1), 1'b0); // trail above range
        send_text(TRAIL_END, 1'b0);
        send_text(ASCII_END, 1'b0);             // bad lead swallows next byte
        send_text(8'h41, 1'b0);
        send_text(LEAD_END, 1'b0);
        send_text(TRAIL_MIN, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b1);
        // table write between lead and trail, then lookup of that entry
        send_text(8'hB0, 1'b0);
        write_entry(1504, 16'h3C3C);
        send_text(TRAIL_MIN, 1'b0);
        send_text(8'hC0, 1'b1);                 // good lead at end of text
        send_text(8'h9F, 1'b1);                 // bad lead at end of text
        send_text(8'h20, 1'b1);
        drain();
    endtask

    task automatic test_output_backpressure();
        src_jitter    = 1'b0;
        sink_hold_req = 160;
        for (int i = 0; i < 24; i++) send_text(BYTE_W'($urandom_range(0, 127)), i == 23);
        drain();
        src_jitter = 1'b1;
    endtask

    task automatic send_wellformed_text();
        int                len;
        int                pick;
        bit                last;
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] trail;
        len = $urandom_range(1, 16);
        for (int c = 0; c < len; c++) begin
            last = (c == len - 1);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 11) == 0) random_write();
            if (pick < 45) begin
                send_text(BYTE_W'($urandom_range(0, 127)), last);
            end else if (pick < 85) begin
                if ($urandom_range(0, 1)) begin
                    lead  = BYTE_W'($urandom_range(LEAD_MIN, LEAD_MIN + 3));
                    trail = BYTE_W'($urandom_range(TRAIL_MIN, TRAIL_MIN + 7));
                end else begin
                    lead  = BYTE_W'($urandom_range(LEAD_MIN, LEAD_END - 1));
                    trail = BYTE_W'($urandom_range(TRAIL_MIN, TRAIL_END - 1));
                end
                send_text(lead, 1'b0);
                if ($urandom_range(0, 9) == 0) random_write();
                send_text(trail, last);
            end else if (pick < 90) begin
                lead = BYTE_W'($urandom_range(0, 1) ? $urandom_range(ASCII_END, LEAD_MIN - 1)
                                                    : $urandom_range(LEAD_END, 255));
                send_text(lead, 1'b0);
                send_text(BYTE_W'($urandom_range(0, 255)), last);
            end else if (pick < 95) begin
                send_text(BYTE_W'($urandom_range(LEAD_MIN, LEAD_END - 1)), 1'b0);
                trail = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, TRAIL_MIN - 1))
                                             : TRAIL_END;
                send_text(trail, last);
            end else begin
                // any lead that closes the text
                send_text(BYTE_W'($urandom_range(ASCII_END, 255)), 1'b1);
                break;
            end
        end
    endtask

    task automatic send_noise_text();
        int len;
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) random_write();
            send_text(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
        end
    endtask

    task automatic test_random_texts(input int n_items, input bit with_idling);
        int stop_at;
        src_jitter  = with_idling;
        sink_jitter = with_idling;
        stop_at     = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) send_noise_text();
            else send_wellformed_text();
        end
        drain();
    endtask

    initial begin
        mismatches    = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        sink_hold_req = 0;
        src_jitter    = 1'b1;
        sink_jitter   = 1'b1;
        held_lead_m   = '0;
        phase_m       = DEC_IDLE;
        char_count_m  = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) entry_loaded[i] = 1'b0;

        rst_n               <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.kind        <= KIND_TEXT;
        byte_ch.byte_value  <= '0;
        byte_ch.end_of_text <= 1'b0;
        byte_ch.entry_index <= '0;
        byte_ch.entry_code  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_texts(1050, 1'b1);
        test_random_texts(500, 1'b0);

        repeat (12) @(posedge clk);
        if (mismatches == 0 && pending_units.size() == 0) begin
            $display("** gb2312_to_ucs2_decoder_unit: PASSED **");
        end else begin
            $display("** gb2312_to_ucs2_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gtu_pkg.sv
rtl/gtu_if.sv
rtl/gtu_map_mem.sv
rtl/gb2312_to_ucs2_decoder_unit.sv
tb/sv/tb_gb2312_to_ucs2_decoder_unit.sv
